/* rtl/mcpw_pkg.sv */
package mcpw_pkg;

    localparam int CHAN_COUNT = 8;
    localparam int ACTIVE     = (CHAN_COUNT >= 8) ? 8 : CHAN_COUNT;
    localparam int IDX_W      = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

    localparam int LEVEL_W = 8;
    localparam int TIMER_W = 16;
    localparam int CHAN_W  = 3;

    localparam logic [LEVEL_W-1:0] ACTIVE_MASK = LEVEL_W'((1 << ACTIVE) - 1);
    localparam logic [LEVEL_W-1:0] ENABLE_RESET = '1;

    typedef struct packed {
        logic              hit;
        logic [CHAN_W-1:0] idx;
    } t_pick;

    typedef struct packed {
        logic               valid;
        logic [CHAN_W-1:0]  channel;
        logic [TIMER_W-1:0] width;
    } t_result;

    typedef struct packed {
        logic advance;
    } t_flow;

    function automatic t_pick pick_lowest(input logic [LEVEL_W-1:0] changed);
        t_pick p;
        p.hit = 1'b0;
        p.idx = '0;
        for (int i = ACTIVE - 1; i >= 0; i--) begin
            if (changed[i]) begin
                p.hit = 1'b1;
                p.idx = CHAN_W'(i);
            end
        end
        return p;
    endfunction

endpackage

/* rtl/mcpw_if.sv */
interface mcpw_in_if;
    logic                         valid;
    logic                         ready;
    logic [mcpw_pkg::LEVEL_W-1:0] pin_levels;
    logic [mcpw_pkg::TIMER_W-1:0] timer_value;
    modport source(output valid, output pin_levels, output timer_value, input ready);
    modport sink(input valid, input pin_levels, input timer_value, output ready);
endinterface

interface mcpw_out_if;
    logic                         valid;
    logic                         ready;
    logic [mcpw_pkg::CHAN_W-1:0]  channel;
    logic [mcpw_pkg::TIMER_W-1:0] pulse_width;
    modport source(output valid, output channel, output pulse_width, input ready);
    modport sink(input valid, input channel, input pulse_width, output ready);
endinterface

interface mcpw_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mcpw_pkg::LEVEL_W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* rtl/mcpw_in_reg.sv */
module mcpw_in_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mcpw_pkg::LEVEL_W-1:0] i_levels,
    input  logic [mcpw_pkg::TIMER_W-1:0] i_timer,
    input  mcpw_pkg::t_flow              i_flow,
    output logic                         o_valid,
    output logic [mcpw_pkg::LEVEL_W-1:0] o_levels,
    output logic [mcpw_pkg::TIMER_W-1:0] o_timer
);

    logic                         r_valid;
    logic [mcpw_pkg::LEVEL_W-1:0] r_levels;
    logic [mcpw_pkg::TIMER_W-1:0] r_timer;
    logic                         n_valid;
    logic                         load;

    assign o_ready = !r_valid || i_flow.advance;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_flow.advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_levels <= i_levels;
            r_timer  <= i_timer;
        end
    end

    assign o_valid  = r_valid;
    assign o_levels = r_levels;
    assign o_timer  = r_timer;

endmodule

/* rtl/mcpw_capture.sv */
module mcpw_capture (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [mcpw_pkg::LEVEL_W-1:0] i_levels,
    input  logic [mcpw_pkg::TIMER_W-1:0] i_timer,
    input  logic [mcpw_pkg::LEVEL_W-1:0] i_enable,
    input  logic                         i_out_free,
    output mcpw_pkg::t_flow              o_flow,
    output mcpw_pkg::t_result            o_result
);

    logic [mcpw_pkg::LEVEL_W-1:0] r_prev;
    logic [mcpw_pkg::TIMER_W-1:0] r_rise [0:mcpw_pkg::ACTIVE-1];

    logic [mcpw_pkg::LEVEL_W-1:0] masked;
    logic [mcpw_pkg::LEVEL_W-1:0] changed;
    mcpw_pkg::t_pick              pick;
    logic [mcpw_pkg::IDX_W-1:0]   ridx;
    logic                         has_rise;
    logic                         has_fall;
    logic                         go;

    assign masked   = i_levels & i_enable & mcpw_pkg::ACTIVE_MASK;
    assign changed  = masked ^ r_prev;
    assign pick     = mcpw_pkg::pick_lowest(changed);
    assign ridx     = pick.idx[mcpw_pkg::IDX_W-1:0];
    assign has_rise = pick.hit && masked[pick.idx];
    assign has_fall = pick.hit && !masked[pick.idx];
    assign go       = i_valid && (i_out_free || !has_fall);

    assign o_flow.advance  = go;

    assign o_result.valid   = go && has_fall;
    assign o_result.channel = pick.idx;
    assign o_result.width   = i_timer - r_rise[ridx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            for (int i = 0; i < mcpw_pkg::ACTIVE; i++) begin
                r_rise[i] <= '0;
            end
        end else if (go) begin
            r_prev <= masked;
            if (has_rise) begin
                r_rise[ridx] <= i_timer;
            end
        end
    end

endmodule

/* rtl/mcpw_out_reg.sv */
module mcpw_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcpw_pkg::t_result i_result,
    output logic              o_out_free,
    mcpw_out_if.source        o_out
);

    logic                         r_valid;
    logic [mcpw_pkg::CHAN_W-1:0]  r_channel;
    logic [mcpw_pkg::TIMER_W-1:0] r_width;
    logic                         n_valid;

    assign o_out_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_channel <= i_result.channel;
            r_width   <= i_result.width;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.channel     = r_channel;
    assign o_out.pulse_width = r_width;

endmodule

/* rtl/multi_channel_pulse_width_capture.sv */
// channel  dir  payload                          accepted when
// i_in     in   pin_levels[7:0], timer_value[15:0] valid && ready
// o_out    out  channel[2:0], pulse_width[15:0]    valid && ready
// i_cfg    in   data[7:0] (channel_enable)         valid && ready (ready always high)
//
// One sample per cycle unless output stalls; widths pass the input and output registers.
// Edge detect, rise-time store and width subtract run in one stage after the input register.
// Synchronous active-low reset clears levels, rise times, valids; enable resets to all ones.
// A stalled output only blocks samples that would produce a width; others keep flowing.
module multi_channel_pulse_width_capture (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcpw_in_if.sink    i_in,
    mcpw_out_if.source o_out,
    mcpw_cfg_if.sink   i_cfg
);

    logic [mcpw_pkg::LEVEL_W-1:0] r_enable;
    logic                         s1_valid;
    logic [mcpw_pkg::LEVEL_W-1:0] s1_levels;
    logic [mcpw_pkg::TIMER_W-1:0] s1_timer;
    logic                         out_free;
    mcpw_pkg::t_flow              flow;
    mcpw_pkg::t_result            result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= mcpw_pkg::ENABLE_RESET;
        end else if (i_cfg.valid) begin
            r_enable <= i_cfg.data;
        end
    end

    mcpw_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_levels (i_in.pin_levels),
        .i_timer  (i_in.timer_value),
        .i_flow   (flow),
        .o_valid  (s1_valid),
        .o_levels (s1_levels),
        .o_timer  (s1_timer)
    );

    mcpw_capture u_capture (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s1_valid),
        .i_levels   (s1_levels),
        .i_timer    (s1_timer),
        .i_enable   (r_enable),
        .i_out_free (out_free),
        .o_flow     (flow),
        .o_result   (result)
    );

    mcpw_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (result),
        .o_out_free (out_free),
        .o_out      (o_out)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid |-> out_free)
        else $error("result would overwrite a pending word");

    a_result_needs_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid |-> s1_valid && flow.advance)
        else $error("result without an advancing sample");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> s1_valid && !out_free)
        else $error("input stalled without a blocked sample");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (32'(o_out.channel) < mcpw_pkg::ACTIVE))
        else $error("channel out of range");

endmodule

/* bench/multi_channel_pulse_width_capture_tb.sv */
`timescale 1ns / 1ps

module multi_channel_pulse_width_capture_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PIPE_SETTLE    = 4;
    localparam int PRINT_CAP      = 30;
    localparam logic [mcpw_pkg::LEVEL_W-1:0] CHAN_MASK =
        (mcpw_pkg::CHAN_COUNT >= mcpw_pkg::LEVEL_W) ? '1 :
        mcpw_pkg::LEVEL_W'((1 << mcpw_pkg::CHAN_COUNT) - 1);

    typedef struct packed {
        logic [mcpw_pkg::CHAN_W-1:0]  channel;
        logic [mcpw_pkg::TIMER_W-1:0] width;
    } t_width_rec;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mcpw_in_if  in_ch();
    mcpw_out_if out_ch();
    mcpw_cfg_if cfg_ch();

    multi_channel_pulse_width_capture i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block state
    logic [mcpw_pkg::LEVEL_W-1:0] enable_shadow = mcpw_pkg::ENABLE_RESET;
    logic [mcpw_pkg::LEVEL_W-1:0] last_levels   = '0;
    logic [mcpw_pkg::TIMER_W-1:0] rise_at [mcpw_pkg::CHAN_COUNT];
    t_width_rec                   expected_widths [$];

    int errors         = 0;
    int samples_taken  = 0;
    int widths_checked = 0;
    int enable_writes  = 0;
    int idle_cycles    = 0;
    int hold_request   = 0;
    bit quiet          = 1'b0;

    logic [mcpw_pkg::LEVEL_W-1:0] pins = '0;
    logic [mcpw_pkg::TIMER_W-1:0] tick = '0;

    initial begin
        for (int i = 0; i < mcpw_pkg::CHAN_COUNT; i++) rise_at[i] = '0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP) $display("mismatch: %s", what);
    endtask

    function automatic void predict_sample(input logic [mcpw_pkg::LEVEL_W-1:0] levels,
                                           input logic [mcpw_pkg::TIMER_W-1:0] stamp);
        logic [mcpw_pkg::LEVEL_W-1:0] masked;
        logic [mcpw_pkg::LEVEL_W-1:0] changed;
        t_width_rec rec;
        masked  = levels & enable_shadow & CHAN_MASK;
        changed = masked ^ last_levels;
        for (int i = 0; i < mcpw_pkg::CHAN_COUNT && i < mcpw_pkg::LEVEL_W; i++) begin
            if (changed[i]) begin
                if (masked[i]) begin
                    rise_at[i] = stamp;
                end else begin
                    rec.channel = mcpw_pkg::CHAN_W'(i);
                    rec.width   = stamp - rise_at[i];
                    expected_widths.push_back(rec);
                end
                break;
            end
        end
        last_levels = masked;
    endfunction

    // predictor and checker, sampled at the clock edge
    always @(posedge i_clk) begin
        t_width_rec want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                enable_shadow = cfg_ch.data;
                enable_writes++;
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_sample(in_ch.pin_levels, in_ch.timer_value);
                samples_taken++;
            end
            if (out_ch.valid && out_ch.ready) begin
                widths_checked++;
                if (expected_widths.size() == 0) begin
                    report_mismatch($sformatf("unexpected word ch %0d width %h",
                                              out_ch.channel, out_ch.pulse_width));
                end else begin
                    want = expected_widths.pop_front();
                    if (out_ch.channel !== want.channel)
                        report_mismatch($sformatf("channel %0d, want %0d",
                                                  out_ch.channel, want.channel));
                    if (out_ch.pulse_width !== want.width)
                        report_mismatch($sformatf("ch %0d width %h, want %h",
                                                  want.channel, out_ch.pulse_width,
                                                  want.width));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("multi_channel_pulse_width_capture verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!quiet) begin
                    r = $urandom_range(0, 99);
                    if (r >= 96)      stall_left = $urandom_range(8, 40);
                    else if (r >= 70) stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(input logic [mcpw_pkg::LEVEL_W-1:0] levels,
                               input logic [mcpw_pkg::TIMER_W-1:0] stamp, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.pin_levels  <= levels;
        in_ch.timer_value <= stamp;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // let an edge pass first so the last accepted word is already predicted
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_widths.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic [mcpw_pkg::LEVEL_W-1:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_and_wrap();
        send_sample(8'h01, 16'h0000, pick_gap());
        send_sample(8'h00, 16'hFFFF, pick_gap());
        send_sample(8'h80, 16'hFFF0, pick_gap());
        send_sample(8'h00, 16'h0010, pick_gap());
        send_sample(8'h40, 16'h1234, pick_gap());
        send_sample(8'h00, 16'h1234, pick_gap());
    endtask

    // ch1 rises alongside ch0 and is dropped, so its fall measures from zero
    task automatic test_simultaneous_edges();
        send_sample(8'h03, 16'h0100, pick_gap());
        send_sample(8'h02, 16'h0150, pick_gap());
        send_sample(8'h00, 16'h0200, pick_gap());
        send_sample(8'hFF, 16'h0300, pick_gap());
        send_sample(8'h00, 16'h0400, pick_gap());
    endtask

    task automatic test_enable_masking();
        write_enable(8'h00);
        send_sample(8'hFF, 16'h0500, pick_gap());
        send_sample(8'h00, 16'h0510, pick_gap());
        write_enable(8'hFF);
        send_sample(8'h10, 16'h0600, pick_gap());
        write_enable(8'hEF);
        send_sample(8'h10, 16'h0700, pick_gap());
        write_enable(8'hFF);
        send_sample(8'h10, 16'h0800, pick_gap());
        send_sample(8'h00, 16'h0900, pick_gap());
        pins = '0;
    endtask

    task automatic test_random_traffic(input logic [mcpw_pkg::LEVEL_W-1:0] enable,
                                       input int count);
        int r;
        write_enable(enable);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 75)
                pins = pins ^ (mcpw_pkg::LEVEL_W'(1) <<
                               $urandom_range(0, mcpw_pkg::LEVEL_W - 1));
            else if (r < 90)
                pins = pins ^ mcpw_pkg::LEVEL_W'($urandom);
            else
                pins = mcpw_pkg::LEVEL_W'($urandom);
            if ($urandom_range(0, 9) == 0)
                tick = mcpw_pkg::TIMER_W'($urandom);
            else
                tick = tick + mcpw_pkg::TIMER_W'($urandom_range(0, 400));
            send_sample(pins, tick, pick_gap());
        end
        quiet = 1'b0;
    endtask

    // long receiver hold-off while samples keep coming back to back
    task automatic test_backpressure();
        drain();
        quiet = 1'b1;
        hold_request = 300;
        for (int n = 0; n < 64; n++) begin
            pins = pins ^ 8'h01;
            tick = tick + mcpw_pkg::TIMER_W'($urandom_range(1, 50));
            send_sample(pins, tick, 0);
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.pin_levels  = '0;
        in_ch.timer_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_wrap();
        test_simultaneous_edges();
        test_enable_masking();
        test_random_traffic(8'hFF, 400);
        test_random_traffic(mcpw_pkg::LEVEL_W'($urandom_range(1, 254)), 400);
        test_backpressure();
        test_random_traffic(8'h81, 300);
        test_random_traffic(8'h00, 50);
        test_random_traffic(mcpw_pkg::LEVEL_W'($urandom_range(1, 254)), 300);
        test_random_traffic(8'hFF, 300);

        drain();
        repeat (10) @(posedge i_clk);
        $display("ran %0d samples through %0d enable settings, %0d widths compared",
                 samples_taken, enable_writes, widths_checked);
        if (errors == 0 && expected_widths.size() == 0) begin
            $display("multi_channel_pulse_width_capture verification clean");
        end else begin
            $display("multi_channel_pulse_width_capture verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mcpw_pkg.sv
rtl/mcpw_if.sv
rtl/mcpw_in_reg.sv
rtl/mcpw_capture.sv
rtl/mcpw_out_reg.sv
rtl/multi_channel_pulse_width_capture.sv
bench/multi_channel_pulse_width_capture_tb.sv
